>>> hw/rtl/fifo_with_match_delete_top_assert.svh
// Assertion macros used by the queue datapath.
`ifndef FIFO_WITH_MATCH_DELETE_TOP_ASSERT_SVH
`define FIFO_WITH_MATCH_DELETE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Implication: whenever ante holds, cons holds in the next cycle.
`define FWMD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fwmd implication check failed");
// Invariant: cond holds at every clock edge out of reset.
`define FWMD_ASSERT_ALW(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("fwmd invariant check failed");
`else
`define FWMD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FWMD_ASSERT_ALW(lbl, clk, rstn, cond)
`endif
`endif

>>> hw/rtl/fwmd_pkg.sv
// Shared types and constants of the queue with delete by value.
`default_nettype none
package fwmd_pkg;

    localparam int TAG_PORT_W = 32;
    localparam int REQ_W      = 2;
    localparam int STAT_W     = 2;
    localparam int FILL_W     = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_DEL  = 2'd2,
        REQ_RSVD = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_NULL = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic apply;
    } ctrl_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/fifo_with_match_delete_top.sv
// Top level of the ordered tag queue with dequeue and delete by value.
//
// Channel   Handshake                Payload
// request   start / busy             req_type, tag_in
// result    done (one-cycle strobe)  status, tag_out, fill_count
//
// A request is accepted at a rising edge with start high and busy low.
// In the accept cycle tag_in is compared with every occupied slot in parallel;
// in the next cycle, with busy high, the queue and the result are updated.
// done is high for exactly one cycle after that, while the next request may
// already be accepted. No request is taken while busy; the receiver cannot stall.
// Reset clears the queue count and control state, not the slots or fill_count.
`default_nettype none
module fifo_with_match_delete_top #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 32
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire  [fwmd_pkg::REQ_W-1:0]         req_type,
    input  wire  [fwmd_pkg::TAG_PORT_W-1:0]    tag_in,
    output logic                               done,
    output logic [fwmd_pkg::STAT_W-1:0]        status,
    output logic [fwmd_pkg::TAG_PORT_W-1:0]    tag_out,
    output logic [fwmd_pkg::FILL_W-1:0]        fill_count
);
    import fwmd_pkg::*;

    // Commands that step the datapath through capture and apply.
    ctrl_cmd_t cmd;

    fwmd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the slots, the fill count and the result registers.
    fwmd_dpath #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .tag_in     (tag_in),
        .status     (status),
        .tag_out    (tag_out),
        .fill_count (fill_count)
    );

endmodule
`default_nettype wire

>>> hw/rtl/fwmd_ctrl.sv
// Controller state machine: sequences capture and apply of each request.
`default_nettype none
module fwmd_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    output logic                 done,
    output fwmd_pkg::ctrl_cmd_t  cmd
);
    import fwmd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.apply   = 1'b0;
        busy        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_APPLY;
                end
            end
            S_APPLY:
            begin
                busy       = 1'b1;
                cmd.apply  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done_next = cmd.apply;
    assign done      = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/fwmd_dpath.sv
// Datapath: tag slots as a shift line, parallel match, count and result registers.
`default_nettype none
`include "fifo_with_match_delete_top_assert.svh"
module fwmd_dpath #(
    parameter int DEPTH     = 16,
    parameter int TAG_WIDTH = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  fwmd_pkg::ctrl_cmd_t                   cmd,
    input  wire  [fwmd_pkg::REQ_W-1:0]            req_type,
    input  wire  [fwmd_pkg::TAG_PORT_W-1:0]       tag_in,
    output logic [fwmd_pkg::STAT_W-1:0]           status,
    output logic [fwmd_pkg::TAG_PORT_W-1:0]       tag_out,
    output logic [fwmd_pkg::FILL_W-1:0]           fill_count
);
    import fwmd_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [TAG_WIDTH-1:0]  slot_reg [DEPTH];
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DEPTH-1:0]      match_reg, match_next;
    logic [DEPTH-1:0]      at_tail, shift_mask, write_vec, prefix;
    req_t                  req_reg;
    logic [TAG_WIDTH-1:0]  tag_reg, tag_w;
    status_t               status_reg, status_next;
    logic [TAG_PORT_W-1:0] tag_out_reg, tag_out_next;
    logic [FILL_W-1:0]     fill_reg;
    logic                  null_tag, full, empty;

    assign tag_w = TAG_WIDTH'(tag_in);

    // Parallel compare against every occupied slot.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_next[i] = (CNT_W'(i) < count_reg) && (slot_reg[i] == tag_w);
            at_tail[i]    = (CNT_W'(i) == count_reg);
        end
    end

    // Prefix OR of the match vector in log steps: every slot at or after the
    // first match takes its neighbor's tag.
    always_comb
    begin
        prefix = match_reg;
        for (int s = 1; s < DEPTH; s = s * 2)
        begin
            prefix = prefix | (prefix << s);
        end
    end

    assign null_tag = (tag_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        status_next  = ST_OK;
        tag_out_next = '0;
        count_next   = count_reg;
        shift_mask   = '0;
        write_vec    = '0;
        unique case (req_reg)
            REQ_ENQ:
            begin
                if (null_tag)
                begin
                    status_next = ST_NULL;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    write_vec  = at_tail;
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            REQ_DEQ:
            begin
                if (empty)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    tag_out_next = TAG_PORT_W'(slot_reg[0]);
                    shift_mask   = '1;
                    count_next   = CNT_W'(count_reg - 1'b1);
                end
            end
            REQ_DEL:
            begin
                if (null_tag)
                begin
                    status_next = ST_NULL;
                end
                else if (|match_reg)
                begin
                    shift_mask = prefix;
                    count_next = CNT_W'(count_reg - 1'b1);
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_t'(req_type);
            tag_reg   <= tag_w;
            match_reg <= match_next;
        end
        if (cmd.apply)
        begin
            status_reg  <= status_next;
            tag_out_reg <= tag_out_next;
            fill_reg    <= FILL_W'(count_next);
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_slot
        if (g < DEPTH - 1)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (cmd.apply && shift_mask[g])
                begin
                    slot_reg[g] <= slot_reg[g+1];
                end
                else if (cmd.apply && write_vec[g])
                begin
                    slot_reg[g] <= tag_reg;
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (cmd.apply && write_vec[g])
                begin
                    slot_reg[g] <= tag_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.apply)
        begin
            count_reg <= count_next;
        end
    end

    assign status     = status_reg;
    assign tag_out    = tag_out_reg;
    assign fill_count = fill_reg;

    `FWMD_ASSERT_ALW(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `FWMD_ASSERT_IMP(a_count_hold, clk, rst_n, !cmd.apply, $stable(count_reg))
    `FWMD_ASSERT_IMP(a_full_count, clk, rst_n, cmd.apply, status_reg != ST_FULL || full)
    `FWMD_ASSERT_IMP(a_tag_only_ok, clk, rst_n, cmd.apply, tag_out_reg == '0 || status_reg == ST_OK)

endmodule
`default_nettype wire
